>>> sv/assert_macros.svh
// Assertion macros shared by the sorted priority stack RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low reset disable.
`define SPS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion on the standard clock and reset ports of this project.
`define SPS_ASSERT_STD(label, prop, msg) `SPS_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

>>> sv/sps_pkg.sv
// Types, codes and constants of the sorted priority stack.
// Depends on nothing; used by every module of the block.
package sps_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned CountW    = $clog2(Depth + 1);
  localparam int unsigned ElemW     = 32;
  localparam int unsigned GradeW    = 12;
  localparam int unsigned CoursesW  = 8;
  localparam int unsigned WeightW   = 16;
  localparam int unsigned PrioW     = 25;
  localparam int unsigned GradeProdW  = GradeW + WeightW;
  localparam int unsigned CourseProdW = CoursesW + WeightW;
  localparam int unsigned CfgIndexW = 8;

  localparam logic [WeightW-1:0] GradeWeightReset  = 16'd1966;
  localparam logic [WeightW-1:0] CourseWeightReset = 16'd1147;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_PEEK  = 2'd2,
    MODE_CLEAR = 2'd3
  } sps_mode_e;

  localparam logic [CfgIndexW-1:0] CfgGradeWeight  = 8'd0;
  localparam logic [CfgIndexW-1:0] CfgCourseWeight = 8'd1;

  typedef struct packed {
    logic [ElemW-1:0]    elem;
    logic [GradeW-1:0]   grade;
    logic [CoursesW-1:0] courses;
    logic [PrioW-1:0]    prio;
  } sps_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic filled;
  } sps_ctrl_t;

endpackage

>>> sv/sorted_priority_stack_unit.sv
// Top level of the sorted priority stack: handshakes, fill count and cell row.
// Depends on sps_pkg, sps_prio, sps_cell and assert_macros.svh.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  mode, elem_value, grade, courses
//   out      output     out_valid_o/out_stall_i top_*, entry_total, is_empty, overflow
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// The accepting edge registers the payload and the weighted products, the cell row then
// registers the compare-and-shift, and the output register then takes the top entry once
// it is empty or out_stall_i is low. The input stalls while a transaction is in the cell
// row, so a new transaction is not accepted until the previous one has left it.
// A result held there by a full output register under out_stall_i keeps the input stalled.
// Reset clears the fill count and handshake state and loads the default weights.
`include "assert_macros.svh"

module sorted_priority_stack_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      mode_i,
  input  logic [sps_pkg::ElemW-1:0]       elem_value_i,
  input  logic [sps_pkg::GradeW-1:0]      grade_i,
  input  logic [sps_pkg::CoursesW-1:0]    courses_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sps_pkg::ElemW-1:0]       top_elem_o,
  output logic [sps_pkg::GradeW-1:0]      top_grade_o,
  output logic [sps_pkg::CoursesW-1:0]    top_courses_o,
  output logic [sps_pkg::PrioW-1:0]       top_priority_o,
  output logic [sps_pkg::CountW-1:0]      entry_total_o,
  output logic                            is_empty_o,
  output logic                            overflow_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sps_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [sps_pkg::WeightW-1:0]     cfg_data_i
);

  logic                          in_fire;
  logic                          a_q, a_d;
  logic                          b_q, b_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_load;
  logic                          ov_q, ov_d;
  logic [sps_pkg::CountW-1:0]    count_q, count_d;
  logic [sps_pkg::WeightW-1:0]   grade_weight_q, course_weight_q;
  sps_pkg::sps_mode_e            mode_q;
  logic [sps_pkg::ElemW-1:0]     elem_q;
  logic [sps_pkg::GradeW-1:0]    grade_q;
  logic [sps_pkg::CoursesW-1:0]  courses_q;
  logic [sps_pkg::PrioW-1:0]     new_prio;
  logic                          do_push, do_pop, is_full;
  sps_pkg::sps_entry_t           new_entry;
  sps_pkg::sps_entry_t           cell_entry [sps_pkg::Depth];
  logic                          cell_go    [sps_pkg::Depth];
  sps_pkg::sps_ctrl_t            cell_ctrl  [sps_pkg::Depth];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grade_weight_q  <= sps_pkg::GradeWeightReset;
      course_weight_q <= sps_pkg::CourseWeightReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        sps_pkg::CfgGradeWeight:  grade_weight_q  <= cfg_data_i;
        sps_pkg::CfgCourseWeight: course_weight_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = a_q || b_q;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q    <= sps_pkg::sps_mode_e'(mode_i);
      elem_q    <= elem_value_i;
      grade_q   <= grade_i;
      courses_q <= courses_i;
    end
  end

  sps_prio u_prio (
    .clk_i           (clk_i),
    .load_i          (in_fire),
    .grade_i         (grade_i),
    .courses_i       (courses_i),
    .grade_weight_i  (grade_weight_q),
    .course_weight_i (course_weight_q),
    .prio_o          (new_prio)
  );

  assign is_full = (count_q == sps_pkg::CountW'(sps_pkg::Depth));
  assign do_push = a_q && (mode_q == sps_pkg::MODE_PUSH) && !is_full;
  assign do_pop  = a_q && (mode_q == sps_pkg::MODE_POP) && (count_q != '0);

  assign new_entry = '{elem: elem_q, grade: grade_q, courses: courses_q, prio: new_prio};

  for (genvar i = 0; i < sps_pkg::Depth; i++) begin : g_cell
    sps_pkg::sps_entry_t up_entry, down_entry;
    logic                up_go;

    assign cell_ctrl[i] = '{push: do_push, pop: do_pop,
                            filled: (count_q > sps_pkg::CountW'(i))};

    if (i == 0) begin : g_first
      assign up_entry = new_entry;
      assign up_go    = 1'b0;
    end else begin : g_inner
      assign up_entry = cell_entry[i-1];
      assign up_go    = cell_go[i-1];
    end

    if (i == sps_pkg::Depth - 1) begin : g_last
      assign down_entry = '0;
    end else begin : g_mid
      assign down_entry = cell_entry[i+1];
    end

    sps_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl[i]),
      .new_i        (new_entry),
      .up_entry_i   (up_entry),
      .up_go_i      (up_go),
      .down_entry_i (down_entry),
      .entry_o      (cell_entry[i]),
      .go_o         (cell_go[i])
    );
  end

  always_comb begin
    count_d = count_q;
    ov_d    = ov_q;
    if (a_q) begin
      ov_d = (mode_q == sps_pkg::MODE_PUSH) && is_full;
      case (mode_q)
        sps_pkg::MODE_PUSH:  if (!is_full) count_d = count_q + 1'b1;
        sps_pkg::MODE_POP:   if (count_q != '0) count_d = count_q - 1'b1;
        sps_pkg::MODE_CLEAR: count_d = '0;
        default: ;
      endcase
    end
  end

  assign out_load    = b_q && (!out_valid_q || !out_stall_i);
  assign a_d         = in_fire;
  assign b_d         = a_q || (b_q && !out_load);
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q         <= 1'b0;
      b_q         <= 1'b0;
      out_valid_q <= 1'b0;
      ov_q        <= 1'b0;
      count_q     <= '0;
    end else begin
      a_q         <= a_d;
      b_q         <= b_d;
      out_valid_q <= out_valid_d;
      ov_q        <= ov_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (count_q != '0) begin
        top_elem_o     <= cell_entry[0].elem;
        top_grade_o    <= cell_entry[0].grade;
        top_courses_o  <= cell_entry[0].courses;
        top_priority_o <= cell_entry[0].prio;
      end else begin
        top_elem_o     <= '0;
        top_grade_o    <= '0;
        top_courses_o  <= '0;
        top_priority_o <= '0;
      end
      entry_total_o <= count_q;
      is_empty_o    <= (count_q == '0);
      overflow_o    <= ov_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `SPS_ASSERT_STD(a_count_bound, count_q <= sps_pkg::CountW'(sps_pkg::Depth),
                  "fill count exceeds the depth")
  `SPS_ASSERT_STD(a_one_in_flight, !(a_q && b_q), "two transactions in the cell row")
  `SPS_ASSERT_STD(a_empty_flag, out_valid_o |-> (is_empty_o == (entry_total_o == '0)),
                  "empty flag disagrees with the entry total")
  `SPS_ASSERT_STD(a_overflow_full,
                  out_valid_o && overflow_o |-> entry_total_o == sps_pkg::CountW'(sps_pkg::Depth),
                  "overflow reported while the store is not full")

endmodule

>>> sv/sps_prio.sv
// Priority unit: registers both weighted products, then adds the Q.16 course product to the grade product cut to Q.8.
// Depends on sps_pkg.
module sps_prio (
  input  logic                           clk_i,
  input  logic                           load_i,
  input  logic [sps_pkg::GradeW-1:0]     grade_i,
  input  logic [sps_pkg::CoursesW-1:0]   courses_i,
  input  logic [sps_pkg::WeightW-1:0]    grade_weight_i,
  input  logic [sps_pkg::WeightW-1:0]    course_weight_i,
  output logic [sps_pkg::PrioW-1:0]      prio_o
);

  logic [sps_pkg::GradeProdW-1:0]  grade_prod_d, grade_prod_q;
  logic [sps_pkg::CourseProdW-1:0] course_prod_d, course_prod_q;

  assign grade_prod_d  = sps_pkg::GradeProdW'(grade_i) * sps_pkg::GradeProdW'(grade_weight_i);
  assign course_prod_d = sps_pkg::CourseProdW'(courses_i)
                         * sps_pkg::CourseProdW'(course_weight_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grade_prod_q  <= grade_prod_d;
      course_prod_q <= course_prod_d;
    end
  end

  // The grade product is taken eight bits down, dropping its low eight fraction
  // bits, and is added to the course product as it stands.
  assign prio_o = sps_pkg::PrioW'(course_prod_q)
                  + sps_pkg::PrioW'(grade_prod_q[sps_pkg::GradeProdW-1:8]);

endmodule

>>> sv/sps_cell.sv
// One slot of the sorted row: compares against a new entry and shifts on a push or a pop.
// Depends on sps_pkg.
module sps_cell (
  input  logic                clk_i,
  input  sps_pkg::sps_ctrl_t  ctrl_i,
  input  sps_pkg::sps_entry_t new_i,
  input  sps_pkg::sps_entry_t up_entry_i,
  input  logic                up_go_i,
  input  sps_pkg::sps_entry_t down_entry_i,
  output sps_pkg::sps_entry_t entry_o,
  output logic                go_o
);

  sps_pkg::sps_entry_t entry_d, entry_q;

  // The new entry belongs at or above this slot once this slot is free or
  // holds a priority no greater than the new one.
  assign go_o = !ctrl_i.filled || (entry_q.prio <= new_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push) begin
      if (up_go_i) begin
        entry_d = up_entry_i;
      end else if (go_o) begin
        entry_d = new_i;
      end
    end else if (ctrl_i.pop) begin
      entry_d = down_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
